// ===== src/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg: shared constants and types of the tap tempo unit
// Fixed-point formats, function and register codes, controller command and
// status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  // Fixed-point format of the tempo values
  localparam int unsigned FRAC_BITS = 4;
  localparam longint unsigned ONE_BPM = 64'd1 << FRAC_BITS;

  // Field widths
  localparam int unsigned TEMPO_W    = 13;
  localparam int unsigned BEAT_W     = 17;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TAPS_W     = 8;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 8;

  localparam longint unsigned TEMPO_MAX = (64'd1 << TEMPO_W) - 1;
  localparam longint unsigned BEAT_MAX  = (64'd1 << BEAT_W) - 1;
  localparam longint unsigned TAPS_MAX  = (64'd1 << TAPS_W) - 1;

  // Dividend numerators: ms per minute in tempo units
  localparam longint unsigned MS_PER_MIN  = 60000;
  localparam longint unsigned BEAT_NUM    = MS_PER_MIN * ONE_BPM;
  localparam longint unsigned TAP_NUM_MAX = BEAT_NUM * TAPS_MAX;
  localparam int unsigned     TAP_NUM_W   = $clog2(TAP_NUM_MAX + 1);

  // Divider width covers 2*num + elapsed for the largest tap run
  localparam int unsigned DIV_W = $clog2(2 * TAP_NUM_MAX + (64'd1 << TIME_W));
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Step down only from 0.1 BPM upward, rounded up to whole units
  localparam longint unsigned STEP_DN_MIN = (ONE_BPM + 9) / 10;
  // Largest whole BPM that fits the tempo field
  localparam longint unsigned ROUND_MAX = (TEMPO_MAX >> FRAC_BITS) << FRAC_BITS;

  // Reset values
  localparam longint unsigned TEMPO_RAW   = 64'd123 << FRAC_BITS;
  localparam longint unsigned TEMPO_RESET = (TEMPO_RAW > TEMPO_MAX) ? TEMPO_MAX : TEMPO_RAW;
  localparam longint unsigned BEAT_RAW    = (2 * BEAT_NUM + TEMPO_RESET) / (2 * TEMPO_RESET);
  localparam longint unsigned BEAT_RESET  = (BEAT_RAW > BEAT_MAX) ? BEAT_MAX : BEAT_RAW;
  localparam longint unsigned TIMEOUT_RESET = 800;
  localparam longint unsigned MIN_GAP_RESET = 200;
  localparam longint unsigned STEP_RESET    = 8;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ENC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROUND = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM_STEP    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // apply the request to the state
    logic div_load;  // start the divider
    logic finish;    // write back the saturated quotient
    logic out_load;  // move the result into the output register
  } ttb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // request needs a division
    logic div_done;  // divider finishes at this edge
    logic out_free;  // output register can take a result
  } ttb_sts_t;

endpackage

`default_nettype wire

// ===== src/ttb_if.sv =====
// ----------------------------------------------------------------------------
// ttb_if: request and result channels of the tap tempo unit
// Valid/ready channels carrying the request and result payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttb_in_if;
  import ttb_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TIME_W-1:0] time_ms;
  logic              enc_a;
  logic              enc_b;

  modport source (output valid, output func, output time_ms, output enc_a,
                  output enc_b, input ready);
  modport sink   (input valid, input func, input time_ms, input enc_a,
                  input enc_b, output ready);
endinterface

interface ttb_out_if;
  import ttb_pkg::*;

  logic               valid;
  logic               ready;
  logic [TEMPO_W-1:0] bpm_out;
  logic [TEMPO_W-1:0] tap_bpm_out;
  logic [BEAT_W-1:0]  beat_length_ms;
  logic               bpm_changed;
  logic               tap_changed;

  modport source (output valid, output bpm_out, output tap_bpm_out,
                  output beat_length_ms, output bpm_changed, output tap_changed,
                  input ready);
  modport sink   (input valid, input bpm_out, input tap_bpm_out,
                  input beat_length_ms, input bpm_changed, input tap_changed,
                  output ready);
endinterface

`default_nettype wire

// ===== src/ttb_div.sv =====
// ----------------------------------------------------------------------------
// ttb_div: serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ttb_pkg::DIV_W-1:0]  dividend,
  input  wire logic [ttb_pkg::DIV_W-1:0]  divisor,
  output logic                            done,
  output logic [ttb_pkg::DIV_W-1:0]       quotient
);
  import ttb_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     den_r, den_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 qbit;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], qbit};
      rem_nxt = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

`default_nettype wire

// ===== src/ttb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttb_ctrl: request sequencer of the tap tempo unit
// Steps each request through execute, divide and write back when needed, and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output ttb_pkg::ttb_cmd_t      cmd,
  input  wire ttb_pkg::ttb_sts_t sts
);
  import ttb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.need_div ? S_LOAD : S_OUT;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign in_ready     = (state_r == S_IDLE);
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.div_load = (state_r == S_LOAD);
  assign cmd.finish   = (state_r == S_FIN);
  assign cmd.out_load = (state_r == S_OUT) && sts.out_free;

endmodule

`default_nettype wire

// ===== src/ttb_dp.sv =====
// ----------------------------------------------------------------------------
// ttb_dp: datapath of the tap tempo unit
// Tempo and tap state, configuration registers, operand setup for the
// shared divider, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ttb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request payload
  input  wire logic [ttb_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [ttb_pkg::TIME_W-1:0]      in_time_ms,
  input  wire logic                            in_enc_a,
  input  wire logic                            in_enc_b,
  // result
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ttb_pkg::TEMPO_W-1:0]          out_bpm,
  output logic [ttb_pkg::TEMPO_W-1:0]          out_tap_bpm,
  output logic [ttb_pkg::BEAT_W-1:0]           out_beat_length,
  output logic                                 out_bpm_changed,
  output logic                                 out_tap_changed,
  // controller link
  input  wire ttb_pkg::ttb_cmd_t               cmd,
  output ttb_pkg::ttb_sts_t                    sts
);
  import ttb_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] timeout_r;
  logic [CFG_DATA_W-1:0] min_gap_r;
  logic [STEP_W-1:0]     step_r;

  // latched request
  logic [FUNC_W-1:0] op_func_r;
  logic [TIME_W-1:0] op_time_r;
  logic              op_a_r;
  logic              op_b_r;

  // tempo state
  logic [TEMPO_W-1:0] tempo_r;
  logic [TEMPO_W-1:0] tap_r;
  logic [BEAT_W-1:0]  beat_r;
  logic               prev_a_r;
  logic               have_r;
  logic [TIME_W-1:0]  first_r;
  logic [TIME_W-1:0]  last_r;
  logic [TAPS_W-1:0]  taps_r;
  logic               bpm_chg_r;
  logic               tap_chg_r;

  // divider operands
  logic                 kind_tap_r;
  logic [TAP_NUM_W-1:0] prod_r;
  logic [TIME_W-1:0]    elapsed_r;

  // output register
  logic               out_valid_r;
  logic [TEMPO_W-1:0] out_bpm_r;
  logic [TEMPO_W-1:0] out_tap_r;
  logic [BEAT_W-1:0]  out_beat_r;
  logic               out_bchg_r;
  logic               out_tchg_r;

  // execute-stage logic
  logic [TIME_W-1:0]    gap;
  logic                 timed_out;
  logic                 have_eff;
  logic [TAPS_W-1:0]    taps_eff;
  logic [TAPS_W-1:0]    taps_inc;
  logic                 tap_est;
  logic                 enc_rise;
  logic [TEMPO_W-1:0]   tempo_dn;
  logic [TEMPO_W:0]     tempo_sum;
  logic [TEMPO_W-1:0]   tempo_up;
  logic [TEMPO_W-1:0]   tempo_step;
  logic [TEMPO_W:0]     rnd_sum;
  logic [TEMPO_W:0]     rnd_val;
  logic [TEMPO_W-1:0]   tap_rnd;

  // divider link
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // Tap run bookkeeping
  assign gap       = op_time_r - last_r;
  assign timed_out = gap > TIME_W'(timeout_r);
  assign have_eff  = have_r && !timed_out;
  assign taps_eff  = timed_out ? '0 : taps_r;
  assign taps_inc  = (taps_eff == TAPS_W'(TAPS_MAX)) ? taps_eff : taps_eff + 1'b1;
  assign tap_est   = have_eff && (gap > TIME_W'(min_gap_r));

  // Encoder step, saturating both ways
  assign enc_rise  = !prev_a_r && op_a_r;
  assign tempo_dn  = (tempo_r < TEMPO_W'(STEP_DN_MIN)) ? tempo_r :
                     (tempo_r > TEMPO_W'(step_r)) ? tempo_r - TEMPO_W'(step_r) : '0;
  assign tempo_sum = {1'b0, tempo_r} + (TEMPO_W+1)'(step_r);
  assign tempo_up  = (tempo_sum > (TEMPO_W+1)'(TEMPO_MAX)) ? TEMPO_W'(TEMPO_MAX)
                                                           : tempo_sum[TEMPO_W-1:0];
  assign tempo_step = op_b_r ? tempo_dn : tempo_up;

  // Round tap estimate to whole BPM, half up
  assign rnd_sum = {1'b0, tap_r} + (TEMPO_W+1)'(ONE_BPM / 2);
  assign rnd_val = {rnd_sum[TEMPO_W:FRAC_BITS], FRAC_BITS'(0)};
  assign tap_rnd = (rnd_val > (TEMPO_W+1)'(TEMPO_MAX)) ? TEMPO_W'(ROUND_MAX)
                                                       : rnd_val[TEMPO_W-1:0];

  assign sts.need_div = ((op_func_r == FUNC_ENC) && enc_rise) ||
                        (op_func_r == FUNC_SET) ||
                        ((op_func_r == FUNC_TAP) && tap_est);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  // Configuration writes; other indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= CFG_DATA_W'(TIMEOUT_RESET);
      min_gap_r <= CFG_DATA_W'(MIN_GAP_RESET);
      step_r    <= STEP_W'(STEP_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TAP_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_TAP_MIN_GAP: min_gap_r <= cfg_wdata;
        CFG_BPM_STEP:    step_r    <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func_r <= in_func;
      op_time_r <= in_time_ms;
      op_a_r    <= in_enc_a;
      op_b_r    <= in_enc_b;
    end
  end

  // Divider operands: tap (2*num + e) / 2e, beat (2*num + q) / 2q
  always_comb begin
    if (kind_tap_r) begin
      div_dividend = DIV_W'({prod_r, 1'b0}) + DIV_W'(elapsed_r);
      div_divisor  = DIV_W'({elapsed_r, 1'b0});
    end else begin
      div_dividend = DIV_W'(2 * BEAT_NUM) + DIV_W'(tempo_r);
      div_divisor  = DIV_W'({tempo_r, 1'b0});
    end
  end

  ttb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_load),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Operand products for a tap estimate
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod_r    <= TAP_NUM_W'(BEAT_NUM) * TAP_NUM_W'(taps_inc);
      elapsed_r <= op_time_r - first_r;
    end
  end

  // Tempo state update and write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r    <= TEMPO_W'(TEMPO_RESET);
      tap_r      <= '0;
      beat_r     <= BEAT_W'(BEAT_RESET);
      prev_a_r   <= 1'b1;
      have_r     <= 1'b0;
      first_r    <= '0;
      last_r     <= '0;
      taps_r     <= '0;
      bpm_chg_r  <= 1'b0;
      tap_chg_r  <= 1'b0;
      kind_tap_r <= 1'b0;
    end else if (cmd.exec) begin
      bpm_chg_r <= 1'b0;
      tap_chg_r <= 1'b0;
      case (op_func_r)
        FUNC_ENC: begin
          prev_a_r <= op_a_r;
          if (enc_rise) begin
            tempo_r    <= tempo_step;
            bpm_chg_r  <= 1'b1;
            kind_tap_r <= 1'b0;
          end
        end
        FUNC_TAP: begin
          last_r <= op_time_r;
          have_r <= 1'b1;
          if (!have_eff) begin
            first_r <= op_time_r;
            taps_r  <= taps_eff;
          end else if (tap_est) begin
            taps_r     <= taps_inc;
            tap_chg_r  <= 1'b1;
            kind_tap_r <= 1'b1;
          end
        end
        FUNC_SET: begin
          tempo_r    <= tap_r;
          bpm_chg_r  <= 1'b1;
          kind_tap_r <= 1'b0;
        end
        FUNC_ROUND: begin
          tap_r     <= tap_rnd;
          tap_chg_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.finish) begin
      // saturate the quotient to its field
      if (kind_tap_r) begin
        tap_r <= (div_quo > DIV_W'(TEMPO_MAX)) ? TEMPO_W'(TEMPO_MAX)
                                               : div_quo[TEMPO_W-1:0];
      end else begin
        beat_r <= (div_quo > DIV_W'(BEAT_MAX)) ? BEAT_W'(BEAT_MAX)
                                               : div_quo[BEAT_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bpm_r  <= tempo_r;
      out_tap_r  <= tap_r;
      out_beat_r <= beat_r;
      out_bchg_r <= bpm_chg_r;
      out_tchg_r <= tap_chg_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bpm         = out_bpm_r;
  assign out_tap_bpm     = out_tap_r;
  assign out_beat_length = out_beat_r;
  assign out_bpm_changed = out_bchg_r;
  assign out_tap_changed = out_tchg_r;

endmodule

`default_nettype wire

// ===== src/tap_tempo_bpm_unit.sv =====
// Flow: a request runs through execute and output; a division (set, encoder
//   rising edge, tap estimate) adds divider load, divide and write back between.
// Requests: one at a time; a new one is taken once the last result has moved into
//   the output register. The serial divider makes one quotient bit per cycle.
// Reset: synchronous, active low; tempo 123 BPM, beat 488 ms, tap state cleared.
// ----------------------------------------------------------------------------
// tap_tempo_bpm_unit: tempo unit with tap tempo estimation
// Encoder stepping, tap estimation, set and round requests; one result per
// request with tempo, tap estimate and beat length.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_bpm_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ttb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ttb_in_if.sink                               in_ch,
  ttb_out_if.source                            out_ch
);
  import ttb_pkg::*;

  ttb_cmd_t cmd;
  ttb_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ttb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ttb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_ch.func),
    .in_time_ms      (in_ch.time_ms),
    .in_enc_a        (in_ch.enc_a),
    .in_enc_b        (in_ch.enc_b),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_bpm         (out_ch.bpm_out),
    .out_tap_bpm     (out_ch.tap_bpm_out),
    .out_beat_length (out_ch.beat_length_ms),
    .out_bpm_changed (out_ch.bpm_changed),
    .out_tap_changed (out_ch.tap_changed),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

// ===== src/ttb_checker.sv =====
// ----------------------------------------------------------------------------
// ttb_checker: port-level checks of the tap tempo unit
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ttb_pkg::TEMPO_W-1:0]    bpm_out,
  input wire logic [ttb_pkg::TEMPO_W-1:0]    tap_bpm_out,
  input wire logic [ttb_pkg::BEAT_W-1:0]     beat_length_ms,
  input wire logic                           bpm_changed,
  input wire logic                           tap_changed
);
  import ttb_pkg::*;

  // No result comes out of reset
  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bpm_out) &&
    $stable(tap_bpm_out) && $stable(beat_length_ms))
    else $error("stalled result changed");

  // The unit does not take another request in the cycle after it takes one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // A request changes the tempo or the tap estimate, never both
  a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(bpm_changed && tap_changed))
    else $error("both change flags set");

  // Zero tempo gives the saturated beat length
  a_zero_tempo_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (bpm_out == '0) |-> (beat_length_ms == BEAT_W'(BEAT_MAX)))
    else $error("beat length not saturated at zero tempo");

endmodule

bind tap_tempo_bpm_unit ttb_checker u_ttb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .bpm_out        (out_ch.bpm_out),
  .tap_bpm_out    (out_ch.tap_bpm_out),
  .beat_length_ms (out_ch.beat_length_ms),
  .bpm_changed    (out_ch.bpm_changed),
  .tap_changed    (out_ch.tap_changed)
);

`default_nettype wire
